@@ rtl/float_narrow_convert_core_assert.svh @@
// Assertion macros used by the fnc_checker module.
`ifndef FLOAT_NARROW_CONVERT_CORE_ASSERT_SVH
`define FLOAT_NARROW_CONVERT_CORE_ASSERT_SVH
`define FNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/fnc_pkg.sv @@
`default_nettype none
package fnc_pkg;
  localparam int WideWidth = 64;
  localparam int NarrowWidth = 32;
  localparam int WideFracBits = 52;
  localparam int NarrowFracBits = 23;
  localparam int WexpBits = WideWidth - 1 - WideFracBits;
  localparam int NexpBits = NarrowWidth - 1 - NarrowFracBits;
  localparam int WexpMax = (1 << WexpBits) - 1;
  localparam int NexpMax = (1 << NexpBits) - 1;
  localparam int Wbias = (1 << (WexpBits - 1)) - 1;
  localparam int Nbias = (1 << (NexpBits - 1)) - 1;
  localparam int MantBits = WideFracBits + 1;
  localparam int BaseShift = WideFracBits - NarrowFracBits;
  localparam int MaxShift = WideFracBits + 2;
  localparam int ShBits = $clog2(MaxShift + 1);
  localparam int EwBits = WexpBits + 2;

  // stage 1 -> 2 decode
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic [NarrowWidth-2:0]  special_mag;
    logic                    normal;
    logic [NexpBits-1:0]     nexp_m1;
    logic [ShBits-1:0]       shift;
    logic [MantBits-1:0]     mant;
  } dec_t;

  // stage 2 -> 3 shifted mantissa
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic [NarrowWidth-2:0]  special_mag;
    logic                    normal;
    logic [NexpBits-1:0]     nexp_m1;
    logic [MantBits-1:0]     q;
    logic                    guard;
    logic                    sticky;
  } shf_t;
endpackage
`default_nettype wire

@@ rtl/fnc_decode.sv @@
`default_nettype none
module fnc_decode import fnc_pkg::*; (
  input  wire logic [WideWidth-1:0] wide_value,
  output dec_t                      dec
);
  logic                  sign;
  logic [WexpBits-1:0]   e;
  logic [WideFracBits-1:0] frac;
  logic signed [EwBits-1:0] ne;
  logic signed [EwBits-1:0] sh_full;
  logic [NarrowWidth-2:0] inf_mag;

  always_comb begin
    sign = wide_value[WideWidth-1];
    e = wide_value[WideWidth-2 -: WexpBits];
    frac = wide_value[WideFracBits-1:0];
    inf_mag = {{NexpBits{1'b1}}, {NarrowFracBits{1'b0}}};
    sh_full = '0;
    dec = '0;
    dec.sign = sign;
    dec.mant = (e == '0) ? {1'b0, frac} : {1'b1, frac};
    ne = EwBits'($signed({2'b00, (e == '0) ? WexpBits'(1) : e}))
         - EwBits'(Wbias) + EwBits'(Nbias);
    if (e == WexpBits'(WexpMax)) begin
      dec.special = 1'b1;
      if (frac != '0) begin
        dec.sign = 1'b0;
        dec.special_mag = inf_mag | (NarrowWidth-1)'(1 << (NarrowFracBits - 1));
      end else begin
        dec.special_mag = inf_mag;
      end
    end else if (e == '0 && frac == '0) begin
      dec.special = 1'b1;
    end else if (ne >= EwBits'(NexpMax)) begin
      dec.special = 1'b1;
      dec.special_mag = inf_mag;
    end else if (ne >= EwBits'(1)) begin
      dec.normal = 1'b1;
      dec.nexp_m1 = NexpBits'(ne - EwBits'(1));
      dec.shift = ShBits'(BaseShift);
    end else begin
      sh_full = EwBits'(BaseShift + 1) - ne;
      dec.shift = (sh_full > EwBits'(MaxShift)) ? ShBits'(MaxShift) : ShBits'(sh_full);
    end
  end
endmodule
`default_nettype wire

@@ rtl/fnc_shift.sv @@
`default_nettype none
module fnc_shift import fnc_pkg::*; (
  input  wire dec_t d,
  output shf_t s
);
  logic [2*MantBits-1:0] wide;
  logic [MantBits-1:0]   low;
  always_comb begin
    wide = {d.mant, {MantBits{1'b0}}} >> d.shift;
    low = wide[MantBits-1:0];
    s.sign = d.sign;
    s.special = d.special;
    s.special_mag = d.special_mag;
    s.normal = d.normal;
    s.nexp_m1 = d.nexp_m1;
    s.q = wide[2*MantBits-1:MantBits];
    s.guard = low[MantBits-1];
    s.sticky = |low[MantBits-2:0];
  end
endmodule
`default_nettype wire

@@ rtl/fnc_round.sv @@
`default_nettype none
module fnc_round import fnc_pkg::*; (
  input  wire shf_t                   s,
  output logic [NarrowWidth-1:0]      narrow_value
);
  logic [NarrowWidth-1:0] q;
  logic [NarrowWidth-1:0] mag;
  logic [NarrowWidth-1:0] inf_bits;
  always_comb begin
    inf_bits = NarrowWidth'(NexpMax) << NarrowFracBits;
    q = NarrowWidth'(s.q) + NarrowWidth'(s.guard && (s.sticky || s.q[0]));
    if (s.normal) begin
      mag = (NarrowWidth'(s.nexp_m1) << NarrowFracBits) + q;
    end else begin
      mag = q;
    end
    if (mag >= inf_bits) mag = inf_bits;
    if (s.special) begin
      narrow_value = {s.sign, s.special_mag};
    end else begin
      narrow_value = {s.sign, mag[NarrowWidth-2:0]};
    end
  end
endmodule
`default_nettype wire

@@ rtl/float_narrow_convert_core.sv @@
`default_nettype none
// Wide-to-narrow IEEE float conversion, round to nearest even.
// Pipeline: decode, shift and round, each registered (dec_r, shf_r, narrow_value).
// Throughput: one transaction per cycle while ready_out stays high; every stage advances when the one after is free.
// Reset: rst (synchronous) clears all stage valid bits; payload registers are not reset.
module float_narrow_convert_core import fnc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   valid_in,
  output logic                        ready_in,
  input  wire logic [WideWidth-1:0]   wide_value,
  output logic                        valid_out,
  input  wire logic                   ready_out,
  output logic [NarrowWidth-1:0]      narrow_value
);
  dec_t dec_c, dec_r;
  shf_t shf_c, shf_r;
  logic [NarrowWidth-1:0] res_c;
  logic v1, v2, v3;
  logic en1, en2, en3;

  fnc_decode u_dec (.wide_value(wide_value), .dec(dec_c));
  fnc_shift  u_shf (.d(dec_r), .s(shf_c));
  fnc_round  u_rnd (.s(shf_r), .narrow_value(res_c));

  always_comb begin
    en3 = !v3 || ready_out;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
    ready_in = en1;
    valid_out = v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= valid_in;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en1) dec_r <= dec_c;
    if (en2) shf_r <= shf_c;
    if (en3) narrow_value <= res_c;
  end
endmodule
`default_nettype wire

@@ rtl/fnc_checker.sv @@
`default_nettype none
`include "float_narrow_convert_core_assert.svh"
module fnc_checker import fnc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 valid_in,
  input wire logic                 ready_in,
  input wire logic [WideWidth-1:0] wide_value,
  input wire logic                 valid_out,
  input wire logic                 ready_out,
  input wire logic [NarrowWidth-1:0] narrow_value
);
  logic                   out_nan;
  logic [NarrowWidth-1:0] canon_nan;

  assign out_nan = (&narrow_value[NarrowWidth-2:NarrowFracBits])
                   && (|narrow_value[NarrowFracBits-1:0]);
  assign canon_nan = {1'b0, {NexpBits{1'b1}}, 1'b1, {(NarrowFracBits-1){1'b0}}};

  `FNC_ASSERT_NEXT(a_out_hold, valid_out && !ready_out, valid_out && $stable(narrow_value), "out hold")
  `FNC_ASSERT_IMPL(a_ready_free, !valid_out, ready_in, "input blocked with empty output")
  `FNC_ASSERT_NEXT(a_in_hold, valid_in && !ready_in, valid_in && $stable(wide_value), "in hold")
  `FNC_ASSERT_IMPL(a_nan_out, valid_out && out_nan, narrow_value == canon_nan, "noncanonical nan")
endmodule
bind float_narrow_convert_core fnc_checker u_fnc_checker (.*);
`default_nettype wire

@@ tb/float_narrow_convert_core_tb.sv @@
`default_nettype none
module float_narrow_convert_core_tb;
  import fnc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic ready_in;
  logic [WideWidth-1:0] wide_value = '0;
  logic valid_out;
  logic ready_out = 1'b0;
  logic [NarrowWidth-1:0] narrow_value;

  logic [NarrowWidth-1:0] narrow_q[$];
  int errors = 0;
  int idle_pct = 16;
  bit hold_out = 1'b0;
  int hold_cycles = 0;

  float_narrow_convert_core u_dut (
    .clk(clk), .rst(rst), .valid_in(valid_in), .ready_in(ready_in),
    .wide_value(wide_value), .valid_out(valid_out), .ready_out(ready_out),
    .narrow_value(narrow_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

  // Rounds m right by sh, nearest with ties to even.
  function automatic logic [63:0] rne_shift(logic [63:0] m, int sh);
    logic [63:0] q, rem, half;
    if (sh > WideFracBits + 2) sh = WideFracBits + 2;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic logic [NarrowWidth-1:0] narrow_of(logic [WideWidth-1:0] x);
    logic sign;
    logic [WexpBits-1:0] ex;
    logic [WideFracBits-1:0] frac;
    logic [63:0] m, mag, inf_bits;
    int e, ne;
    sign = x[WideWidth-1];
    ex = x[WideWidth-2:WideFracBits];
    frac = x[WideFracBits-1:0];
    inf_bits = 64'(NexpMax) << NarrowFracBits;
    if (ex == WexpBits'(WexpMax)) begin
      if (frac != 0) return NarrowWidth'(inf_bits | (64'd1 << (NarrowFracBits - 1)));
      return {sign, inf_bits[NarrowWidth-2:0]};
    end
    if (ex == 0 && frac == 0) return {sign, {(NarrowWidth-1){1'b0}}};
    if (ex == 0) begin
      m = 64'(frac);
      e = 1;
    end else begin
      m = 64'(frac) | (64'd1 << WideFracBits);
      e = int'(ex);
    end
    ne = e - Wbias + Nbias;
    if (ne >= NexpMax) return {sign, inf_bits[NarrowWidth-2:0]};
    if (ne >= 1)
      mag = (64'(ne - 1) << NarrowFracBits) + rne_shift(m, WideFracBits - NarrowFracBits);
    else
      mag = rne_shift(m, WideFracBits - NarrowFracBits + (1 - ne));
    if (mag >= inf_bits) mag = inf_bits;
    return {sign, mag[NarrowWidth-2:0]};
  endfunction

  // valid_in stays high between back-to-back transactions; it drops on idle
  // cycles and in drain_results.
  task automatic send_wide(logic [WideWidth-1:0] v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      valid_in <= 1'b0;
      @(posedge clk);
    end
    valid_in <= 1'b1;
    wide_value <= v;
    narrow_q.push_back(narrow_of(v));
    @(posedge clk);
    while (!ready_in) @(posedge clk);
  endtask

  task automatic drain_results();
    valid_in <= 1'b0;
    while (narrow_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Receiver side: random stalls plus a forced long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      ready_out <= 1'b0;
    end else if (hold_out) begin
      ready_out <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      ready_out <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && valid_out && ready_out) begin
      if (narrow_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, narrow_value);
        errors++;
      end else begin
        if (narrow_value !== narrow_q[0]) begin
          $display("%0t: narrow_value mismatch, expected %h actual %h",
                   $time, narrow_q[0], narrow_value);
          errors++;
        end
        void'(narrow_q.pop_front());
      end
    end
  end

  function automatic logic [WideWidth-1:0] pack_wide(logic s, int e, logic [51:0] f);
    return {s, WexpBits'(e), f};
  endfunction

  task automatic test_specials();
    send_wide(64'h0);
    send_wide(64'h8000_0000_0000_0000);
    send_wide(64'h7FF0_0000_0000_0000);
    send_wide(64'hFFF0_0000_0000_0000);
    send_wide(64'h7FF8_0000_0000_0000);
    send_wide(64'hFFFF_FFFF_FFFF_FFFF);
    send_wide(64'h7FF0_0000_0000_0001);
    send_wide(64'h0000_0000_0000_0001);
    send_wide(64'h800F_FFFF_FFFF_FFFF);
    send_wide(64'h3FF0_0000_0000_0000);
    send_wide(64'h47EF_FFFF_E000_0000);
    send_wide(64'h47EF_FFFF_F000_0000);
    send_wide(64'hC7F0_0000_0000_0000);
    send_wide(64'h7FEF_FFFF_FFFF_FFFF);
    send_wide(64'h3810_0000_0000_0000);
    send_wide(64'h380F_FFFF_F000_0000);
    send_wide(64'h36A0_0000_0000_0000);
    send_wide(64'h36A0_0000_0000_0001);
    send_wide(64'hB690_0000_0000_0000);
    send_wide(64'h3FF0_0000_1000_0000);
    send_wide(64'h3FF0_0000_3000_0000);
    send_wide(64'h3FF0_0000_1000_0001);
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [51:0] f;
    int e;
    for (int i = 0; i < n; i++) begin
      f = 52'({$urandom, $urandom});
      // exact halfway case for normal results, odd or even kept lsb
      if ($urandom_range(3) == 0) f[29:0] = {i[0], 1'b1, 28'h0};
      case ($urandom_range(5))
        0: e = $urandom_range(2047);
        1: e = $urandom_range(1023 - 126 + 1, 1023 + 127 - 1);
        2: e = $urandom_range(1023 - 152, 1023 - 124);
        3: e = $urandom_range(1023 + 125, 1023 + 129);
        4: e = ($urandom_range(1)) ? 0 : 2047;
        default: e = $urandom_range(860, 1200);
      endcase
      send_wide(pack_wide(1'($urandom_range(1)), e, f));
    end
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_out = 1'b1;
        wait (hold_cycles >= 60);
        hold_out = 1'b0;
      end
      test_random(20);
    join
    drain_results();
  endtask

  task automatic test_full_rate();
    idle_pct = 0;
    test_random(300);
    idle_pct = 16;
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_specials();
    test_random(600);
    drain_results();
    test_back_pressure();
    test_full_rate();
    test_random(700);
    drain_results();
    if (errors == 0 && narrow_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
